// ----- rtl/core/eapi_pkg.sv -----
// Shared types, constants and arctangent table for the ellipse projection pipeline.
package eapi_pkg;

   localparam int TRIG_STAGES_DEF = 24;
   localparam int SQRT_STEPS      = 33;

   // One rotation vector of the shift-add trig chain.
   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } cordic_vec_type;

   // One digit step of the square root chain.
   typedef struct packed {
      logic [36:0] rem;
      logic [32:0] root;
      logic [65:0] rad;
   } sqrt_step_type;

   // Arctangent of 2^-idx in binary turns (2^32 is one turn).
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] val;
      begin
         case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            5'd24:   val = 32'd41;
            5'd25:   val = 32'd20;
            5'd26:   val = 32'd10;
            5'd27:   val = 32'd5;
            5'd28:   val = 32'd3;
            5'd29:   val = 32'd1;
            5'd30:   val = 32'd1;
            default: val = 32'd0;
         endcase
         return val;
      end
   endfunction

endpackage

// ----- rtl/core/eapi_cordic_cell.sv -----
// One shift-add rotation step of the trig chain, registered.
module eapi_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic                    clock,
   input  logic                    en,
   input  eapi_pkg::cordic_vec_type prev_vec,
   output eapi_pkg::cordic_vec_type next_vec
);
   import eapi_pkg::*;

   cordic_vec_type     vec_ff;
   cordic_vec_type     vec_in;
   logic signed [33:0] dx;
   logic signed [33:0] dy;
   logic signed [33:0] ang;

   // Rotate toward zero residual angle
   always_comb begin
      dx  = prev_vec.y >>> IDX;
      dy  = prev_vec.x >>> IDX;
      ang = $signed({2'b00, atan_turn(5'(IDX))});
      if (!prev_vec.z[33]) begin
         vec_in.x = prev_vec.x - dx;
         vec_in.y = prev_vec.y + dy;
         vec_in.z = prev_vec.z - ang;
      end else begin
         vec_in.x = prev_vec.x + dx;
         vec_in.y = prev_vec.y - dy;
         vec_in.z = prev_vec.z + ang;
      end
   end

   // Advance when the pipeline moves
   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign next_vec = vec_ff;

endmodule

// ----- rtl/core/eapi_sqrt_cell.sv -----
// One restoring digit step of the integer square root chain, registered.
module eapi_sqrt_cell (
   input  logic                   clock,
   input  logic                   en,
   input  eapi_pkg::sqrt_step_type prev_step,
   output eapi_pkg::sqrt_step_type next_step
);
   import eapi_pkg::*;

   sqrt_step_type step_ff;
   sqrt_step_type step_in;
   logic [36:0]   rem_sh;
   logic [34:0]   trial;

   // Bring down two radicand bits and try one root bit
   always_comb begin
      rem_sh       = {prev_step.rem[34:0], prev_step.rad[65:64]};
      trial        = {prev_step.root, 2'b01};
      step_in.rad  = {prev_step.rad[63:0], 2'b00};
      if (rem_sh >= {2'b00, trial}) begin
         step_in.rem  = rem_sh - {2'b00, trial};
         step_in.root = {prev_step.root[31:0], 1'b1};
      end else begin
         step_in.rem  = rem_sh;
         step_in.root = {prev_step.root[31:0], 1'b0};
      end
   end

   // Advance when the pipeline moves
   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign next_step = step_ff;

endmodule

// ----- rtl/core/ellipse_axis_projection_interval.sv -----
// Top level: projection interval of a moving, rotating ellipse onto an axis.
//
//   channel  prefix  direction  transfer carries
//   request  req_    in         time, angles, rate, axes, position, velocity
//   result   rsp_    out        interval_low, interval_high
//
// One request per cycle enters while the pipeline is not held; the depth is set by the
// trig cell chain (one cell per step) and the 33-cell square root chain.
// The whole pipeline advances together; it holds while a result waits untaken
// in the output register, and req_ready follows that.
// Reset clears the valid bits only; data registers carry no reset.
module ellipse_axis_projection_interval #(
   parameter int TRIG_STAGES = eapi_pkg::TRIG_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_time_t,
   input  logic [31:0]        req_axis_angle,
   input  logic [31:0]        req_ellipse_angle,
   input  logic signed [31:0] req_angular_velocity,
   input  logic [31:0]        req_semi_major,
   input  logic [31:0]        req_semi_minor,
   input  logic signed [31:0] req_position_x,
   input  logic signed [31:0] req_position_y,
   input  logic signed [31:0] req_velocity_x,
   input  logic signed [31:0] req_velocity_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [39:0] rsp_interval_low,
   output logic signed [39:0] rsp_interval_high
);
   import eapi_pkg::*;

   localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
   localparam logic signed [33:0] HALF_T   = 34'sd2147483648;
   localparam logic signed [33:0] GAIN     = 34'sd652032874;
   localparam logic signed [53:0] OUT_MAX  = 54'sd549755813887;
   localparam logic signed [53:0] OUT_MIN  = -54'sd549755813888;

   typedef struct packed {
      logic [31:0]        major;
      logic [31:0]        minor;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic [31:0]        tm;
      logic               flip_t;
      logic               flip_a;
   } side_type;

   logic en;

   // Flip a trig output back and clamp it to [-1, 1] in Q1.30
   function automatic logic signed [31:0] fix_trig(input logic signed [33:0] v,
                                                  input logic flip);
      logic signed [33:0] f;
      begin
         f = flip ? -v : v;
         if (f > ONE_Q30) begin
            f = ONE_Q30;
         end else if (f < -ONE_Q30) begin
            f = -ONE_Q30;
         end
         return f[31:0];
      end
   endfunction

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Input register
   logic        v0_ff;
   logic [31:0] tm0_ff, ax0_ff, el0_ff, maj0_ff, min0_ff;
   logic signed [31:0] av0_ff, px0_ff, py0_ff, vx0_ff, vy0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tm0_ff  <= req_time_t;
         ax0_ff  <= req_axis_angle;
         el0_ff  <= req_ellipse_angle;
         av0_ff  <= req_angular_velocity;
         maj0_ff <= req_semi_major;
         min0_ff <= req_semi_minor;
         px0_ff  <= req_position_x;
         py0_ff  <= req_position_y;
         vx0_ff  <= req_velocity_x;
         vy0_ff  <= req_velocity_y;
      end
   end

   // Rotation angle swept since time zero
   logic               v1_ff;
   logic signed [64:0] rot_prod;
   logic [31:0]        rot1_ff, tm1_ff, ax1_ff, el1_ff, maj1_ff, min1_ff;
   logic signed [31:0] px1_ff, py1_ff, vx1_ff, vy1_ff;

   assign rot_prod = av0_ff * $signed({1'b0, tm0_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rot1_ff <= rot_prod[39:8];
         tm1_ff  <= tm0_ff;
         ax1_ff  <= ax0_ff;
         el1_ff  <= el0_ff;
         maj1_ff <= maj0_ff;
         min1_ff <= min0_ff;
         px1_ff  <= px0_ff;
         py1_ff  <= py0_ff;
         vx1_ff  <= vx0_ff;
         vy1_ff  <= vy0_ff;
      end
   end

   // Relative angle and quarter-turn fold for both trig chains
   logic [31:0]        th;
   logic signed [33:0] zt_raw, za_raw;
   cordic_vec_type     vt_in, va_in;
   side_type           side_in;

   always_comb begin
      th     = ax1_ff - el1_ff - rot1_ff;
      zt_raw = 34'(signed'(th));
      za_raw = 34'(signed'(ax1_ff));
      vt_in.x = GAIN;
      vt_in.y = '0;
      va_in.x = GAIN;
      va_in.y = '0;
      side_in.flip_t = 1'b0;
      side_in.flip_a = 1'b0;
      if (zt_raw > ONE_Q30) begin
         vt_in.z = zt_raw - HALF_T;
         side_in.flip_t = 1'b1;
      end else if (zt_raw < -ONE_Q30) begin
         vt_in.z = zt_raw + HALF_T;
         side_in.flip_t = 1'b1;
      end else begin
         vt_in.z = zt_raw;
      end
      if (za_raw > ONE_Q30) begin
         va_in.z = za_raw - HALF_T;
         side_in.flip_a = 1'b1;
      end else if (za_raw < -ONE_Q30) begin
         va_in.z = za_raw + HALF_T;
         side_in.flip_a = 1'b1;
      end else begin
         va_in.z = za_raw;
      end
      side_in.major = maj1_ff;
      side_in.minor = min1_ff;
      side_in.px    = px1_ff;
      side_in.py    = py1_ff;
      side_in.vx    = vx1_ff;
      side_in.vy    = vy1_ff;
      side_in.tm    = tm1_ff;
   end

   // Trig cell chain; side data travels in step
   cordic_vec_type vt_vec [0:TRIG_STAGES];
   cordic_vec_type va_vec [0:TRIG_STAGES];
   side_type       side_ff [0:TRIG_STAGES];
   logic           cv_ff   [0:TRIG_STAGES];
   cordic_vec_type vt0_ff, va0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         vt0_ff     <= vt_in;
         va0_ff     <= va_in;
         side_ff[0] <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (en) begin
         cv_ff[0] <= v1_ff;
      end
   end

   assign vt_vec[0] = vt0_ff;
   assign va_vec[0] = va0_ff;

   for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_trig
      eapi_cordic_cell #(.IDX(k)) u_cell_t (
         .clock    (clock),
         .en       (en),
         .prev_vec (vt_vec[k]),
         .next_vec (vt_vec[k+1])
      );
      eapi_cordic_cell #(.IDX(k)) u_cell_a (
         .clock    (clock),
         .en       (en),
         .prev_vec (va_vec[k]),
         .next_vec (va_vec[k+1])
      );

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k+1] <= side_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[k+1] <= 1'b0;
         end else if (en) begin
            cv_ff[k+1] <= cv_ff[k];
         end
      end
   end

   // Unfold and clamp trig outputs
   logic               v2_ff;
   logic signed [31:0] ct2_ff, st2_ff, ca2_ff, sa2_ff;
   side_type           s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= cv_ff[TRIG_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ct2_ff <= fix_trig(vt_vec[TRIG_STAGES].x, side_ff[TRIG_STAGES].flip_t);
         st2_ff <= fix_trig(vt_vec[TRIG_STAGES].y, side_ff[TRIG_STAGES].flip_t);
         ca2_ff <= fix_trig(va_vec[TRIG_STAGES].x, side_ff[TRIG_STAGES].flip_a);
         sa2_ff <= fix_trig(va_vec[TRIG_STAGES].y, side_ff[TRIG_STAGES].flip_a);
         s2_ff  <= side_ff[TRIG_STAGES];
      end
   end

   // Scaled axes and dot products
   logic [30:0]        act, ast;
   logic [62:0]        pa_full, qa_full;
   logic signed [64:0] dp_sum, dv_sum;
   logic               v3_ff;
   logic [32:0]        pa3_ff, qa3_ff;
   logic signed [34:0] dp3_ff, dv3_ff;
   logic [31:0]        tm3_ff;

   always_comb begin
      act     = ct2_ff[31] ? 31'(-ct2_ff) : ct2_ff[30:0];
      ast     = st2_ff[31] ? 31'(-st2_ff) : st2_ff[30:0];
      pa_full = s2_ff.major * act;
      qa_full = s2_ff.minor * ast;
      dp_sum  = 65'(ca2_ff * s2_ff.px) + 65'(sa2_ff * s2_ff.py);
      dv_sum  = 65'(ca2_ff * s2_ff.vx) + 65'(sa2_ff * s2_ff.vy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa3_ff <= pa_full[62:30];
         qa3_ff <= qa_full[62:30];
         dp3_ff <= dp_sum[64:30];
         dv3_ff <= dv_sum[64:30];
         tm3_ff <= s2_ff.tm;
      end
   end

   // Squares and distance moved along the axis
   logic [33:0]        dv_mag;
   logic [65:0]        moved_full;
   logic               v4_ff;
   logic [65:0]        p24_ff, q24_ff;
   logic signed [34:0] dp4_ff;
   logic               neg4_ff;
   logic [49:0]        mv4_ff;

   assign dv_mag     = dv3_ff[34] ? 34'(-dv3_ff) : dv3_ff[33:0];
   assign moved_full = dv_mag * tm3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p24_ff  <= pa3_ff * pa3_ff;
         q24_ff  <= qa3_ff * qa3_ff;
         dp4_ff  <= dp3_ff;
         neg4_ff <= dv3_ff[34];
         mv4_ff  <= moved_full[65:16];
      end
   end

   // Radicand and centre
   sqrt_step_type      sq_vec [0:SQRT_STEPS];
   logic signed [52:0] ctr_ff [0:SQRT_STEPS];
   logic               sv_ff  [0:SQRT_STEPS];
   sqrt_step_type      sq0_ff;
   logic signed [52:0] ctr_in;

   assign ctr_in = neg4_ff ? 53'(dp4_ff) - $signed({3'b000, mv4_ff})
                           : 53'(dp4_ff) + $signed({3'b000, mv4_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         sq0_ff.rem  <= '0;
         sq0_ff.root <= '0;
         sq0_ff.rad  <= p24_ff + q24_ff;
         ctr_ff[0]   <= ctr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= v4_ff;
      end
   end

   assign sq_vec[0] = sq0_ff;

   // Square root cell chain; centre travels in step
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      eapi_sqrt_cell u_cell (
         .clock     (clock),
         .en        (en),
         .prev_step (sq_vec[k]),
         .next_step (sq_vec[k+1])
      );

      always_ff @(posedge clock) begin
         if (en) begin
            ctr_ff[k+1] <= ctr_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else if (en) begin
            sv_ff[k+1] <= sv_ff[k];
         end
      end
   end

   // Interval ends, saturated, into the output register
   logic signed [53:0] lo_raw, hi_raw, half;
   logic signed [39:0] lo_in, hi_in;
   logic               rsp_valid_ff;
   logic signed [39:0] lo_ff, hi_ff;

   always_comb begin
      half   = $signed({21'd0, sq_vec[SQRT_STEPS].root});
      lo_raw = 54'(ctr_ff[SQRT_STEPS]) - half;
      hi_raw = 54'(ctr_ff[SQRT_STEPS]) + half;
      if (lo_raw > OUT_MAX) begin
         lo_in = OUT_MAX[39:0];
      end else if (lo_raw < OUT_MIN) begin
         lo_in = OUT_MIN[39:0];
      end else begin
         lo_in = lo_raw[39:0];
      end
      if (hi_raw > OUT_MAX) begin
         hi_in = OUT_MAX[39:0];
      end else if (hi_raw < OUT_MIN) begin
         hi_in = OUT_MIN[39:0];
      end else begin
         hi_in = hi_raw[39:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sv_ff[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_interval_low  = lo_ff;
   assign rsp_interval_high = hi_ff;

endmodule

// ----- tb/ellipse_axis_projection_interval_tb.sv -----
// Self-checking testbench for the ellipse axis projection interval pipeline.
module ellipse_axis_projection_interval_tb;

   localparam int LATENCY   = eapi_pkg::TRIG_STAGES_DEF + 41;
   localparam int N_STAGES  = eapi_pkg::TRIG_STAGES_DEF;
   localparam longint ONE_Q30 = 64'sd1073741824;
   localparam longint OUT_MAX = 64'sd549755813887;
   localparam longint OUT_MIN = -64'sd549755813888;

   typedef struct {
      logic [31:0] time_t;
      logic [31:0] axis_angle;
      logic [31:0] ellipse_angle;
      logic [31:0] angular_velocity;
      logic [31:0] semi_major;
      logic [31:0] semi_minor;
      logic [31:0] position_x;
      logic [31:0] position_y;
      logic [31:0] velocity_x;
      logic [31:0] velocity_y;
   } request_type;

   typedef struct {
      logic [39:0] low;
      logic [39:0] high;
   } interval_type;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic [31:0] req_time_t, req_axis_angle, req_ellipse_angle, req_semi_major;
   logic [31:0] req_semi_minor;
   logic signed [31:0] req_angular_velocity, req_position_x, req_position_y;
   logic signed [31:0] req_velocity_x, req_velocity_y;
   logic signed [39:0] rsp_interval_low, rsp_interval_high;

   request_type  pending_requests[$];
   interval_type expected_intervals[$];
   int  mismatch_count = 0;
   int  burst_left = 0, gap_left = 0;
   int  stall_phase = 0;
   bit  hold_for_drain = 0;
   bit  drain_done = 0;
   bit  stimulus_done = 0;

   ellipse_axis_projection_interval dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Shift-add trig: cosine and sine of a binary-turn angle, Q1.30.
   function automatic void turn_trig(input logic [31:0] angle, output longint c,
                                     output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'($signed(angle));
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > ONE_Q30) begin
         z -= 2 * ONE_Q30; flip = 1;
      end else if (z < -ONE_Q30) begin
         z += 2 * ONE_Q30; flip = 1;
      end
      for (int i = 0; i < N_STAGES && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(eapi_pkg::atan_turn(i[4:0]));
         end else begin
            x += dx; y -= dy; z += longint'(eapi_pkg::atan_turn(i[4:0]));
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = (x > ONE_Q30) ? ONE_Q30 : (x < -ONE_Q30) ? -ONE_Q30 : x;
      s = (y > ONE_Q30) ? ONE_Q30 : (y < -ONE_Q30) ? -ONE_Q30 : y;
   endfunction

   function automatic longint clamp_q24(input longint v);
      return (v > OUT_MAX) ? OUT_MAX : (v < OUT_MIN) ? OUT_MIN : v;
   endfunction

   // Predict the interval of one request.
   function automatic interval_type project_interval(input request_type r);
      interval_type res;
      longint ca, sa, ct, st, dp, dv, centre, half;
      logic [63:0] rot, pa, qa, mag, moved, tt;
      logic [65:0] rad, rem, trial;
      logic [32:0] root;
      logic [31:0] th;
      longint prod;
      tt = {32'd0, r.time_t};
      prod = longint'($signed(r.angular_velocity)) * longint'(tt);
      rot = 64'(prod) >> 8;
      th = r.axis_angle - r.ellipse_angle - rot[31:0];
      turn_trig(th, ct, st);
      pa = ({32'd0, r.semi_major} * 64'(ct < 0 ? -ct : ct)) >> 30;
      qa = ({32'd0, r.semi_minor} * 64'(st < 0 ? -st : st)) >> 30;
      rad = 66'(pa) * 66'(pa) + 66'(qa) * 66'(qa);
      rem = 0;
      root = 0;
      for (int k = 32; k >= 0; k--) begin
         rem = (rem << 2) | 66'((rad >> (2 * k)) & 66'd3);
         trial = 66'({root, 2'b01});
         if (rem >= trial) begin
            rem -= trial; root = {root[31:0], 1'b1};
         end else begin
            root = {root[31:0], 1'b0};
         end
      end
      half = longint'(root);
      turn_trig(r.axis_angle, ca, sa);
      dp = (ca * longint'($signed(r.position_x)) + sa * longint'($signed(r.position_y)))
           >>> 30;
      dv = (ca * longint'($signed(r.velocity_x)) + sa * longint'($signed(r.velocity_y)))
           >>> 30;
      mag = 64'(dv < 0 ? -dv : dv);
      moved = (mag * tt) >> 16;
      centre = (dv < 0) ? dp - longint'(moved) : dp + longint'(moved);
      res.low = 40'(clamp_q24(centre - half));
      res.high = 40'(clamp_q24(centre + half));
      return res;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 32'h0003_FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic request_type rand_request();
      request_type r;
      r.time_t = ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(0, 32'h000F_FFFF);
      r.axis_angle = $urandom;
      r.ellipse_angle = ($urandom_range(0, 7) == 0) ? rand_word() : $urandom;
      r.angular_velocity = rand_word();
      r.semi_major = rand_word();
      if (r.semi_major == 0) r.semi_major = 1;
      r.semi_minor = rand_word();
      r.position_x = rand_word();
      r.position_y = rand_word();
      r.velocity_x = rand_word();
      r.velocity_y = rand_word();
      return r;
   endfunction

   function automatic request_type make_request(input logic [31:0] t, a, e, w, mj, mn,
                                                px, py, vx, vy);
      request_type r;
      r.time_t = t; r.axis_angle = a; r.ellipse_angle = e; r.angular_velocity = w;
      r.semi_major = mj; r.semi_minor = mn; r.position_x = px; r.position_y = py;
      r.velocity_x = vx; r.velocity_y = vy;
      return r;
   endfunction

   // Fill the request queue: directed corners, then random; the driver pauses to drain partway.
   initial begin
      request_type r;
      // Axis-aligned, quarter and half turns, tangent zero and infinite.
      pending_requests.push_back(make_request(0, 0, 0, 0, 32'h0001_0000, 32'h0000_8000,
                                              0, 0, 0, 0));
      pending_requests.push_back(make_request(0, 32'h4000_0000, 0, 0, 32'h0001_0000,
                                              32'h0000_8000, 32'h0001_0000, 0, 0, 0));
      pending_requests.push_back(make_request(0, 32'h8000_0000, 32'h4000_0000, 0,
                                              32'h0002_0000, 32'h0001_0000, 0, 0, 0, 0));
      pending_requests.push_back(make_request(0, 32'hC000_0000, 32'h2000_0000, 0,
                                              32'h0002_0000, 32'h0001_0000, 0, 0, 0, 0));
      // Smallest major axis, minor above major.
      pending_requests.push_back(make_request(0, 32'h1234_5678, 0, 0, 1, 32'hFFFF_FFFF,
                                              0, 0, 0, 0));
      pending_requests.push_back(make_request(32'h0001_0000, 32'h2000_0000, 0,
                                              32'h0100_0000, 32'h0000_1000,
                                              32'h0010_0000, 0, 0, 0, 0));
      // Largest axes: radicand overflows 64 bits.
      pending_requests.push_back(make_request(0, 32'h2000_0000, 0, 0, 32'hFFFF_FFFF,
                                              32'hFFFF_FFFF, 0, 0, 0, 0));
      // Far positions and long times: saturation both ways.
      pending_requests.push_back(make_request(32'hFFFF_FFFF, 0, 0, 32'h8000_0000,
                                              32'hFFFF_FFFF, 0, 32'h7FFF_FFFF,
                                              32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                              32'h7FFF_FFFF));
      pending_requests.push_back(make_request(32'hFFFF_FFFF, 32'h8000_0000, 0,
                                              32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                              32'h8000_0000, 32'h8000_0000,
                                              32'h8000_0000, 32'h8000_0000));
      pending_requests.push_back(make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                              32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_requests.push_back(make_request(32'h0000_8000, 32'h0000_0001, 32'h7FFF_FFFF,
                                              32'h0000_0001, 32'h0001_0000, 32'h0000_0000,
                                              32'h0000_0001, 32'hFFFF_FFFF,
                                              32'h0001_0000, 32'hFFFF_0000));
      for (int i = 0; i < 1150; i++) begin
         r = rand_request();
         pending_requests.push_back(r);
      end
   end

   // Driver: bursts and gaps, with one full drain partway through.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_time_t <= '0;
         req_axis_angle <= '0;
         req_ellipse_angle <= '0;
         req_angular_velocity <= '0;
         req_semi_major <= 32'd1;
         req_semi_minor <= '0;
         req_position_x <= '0;
         req_position_y <= '0;
         req_velocity_x <= '0;
         req_velocity_y <= '0;
      end else if (req_valid && !req_ready) begin
         // hold until the transfer completes
      end else begin
         bit send;
         send = 0;
         if (!drain_done && pending_requests.size() == 1100) begin
            hold_for_drain = 1;
            drain_done = 1;
         end
         if (hold_for_drain && expected_intervals.size() == 0 && !req_valid)
            hold_for_drain = 0;
         if (!hold_for_drain && pending_requests.size() > 0) begin
            if (burst_left > 0) begin
               burst_left--; send = 1;
            end else if (gap_left > 0) begin
               gap_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               send = 1;
            end
         end
         if (send) begin
            request_type r;
            r = pending_requests.pop_front();
            expected_intervals.push_back(project_interval(r));
            req_valid <= 1'b1;
            req_time_t <= r.time_t;
            req_axis_angle <= r.axis_angle;
            req_ellipse_angle <= r.ellipse_angle;
            req_angular_velocity <= r.angular_velocity;
            req_semi_major <= r.semi_major;
            req_semi_minor <= r.semi_minor;
            req_position_x <= r.position_x;
            req_position_y <= r.position_y;
            req_velocity_x <= r.velocity_x;
            req_velocity_y <= r.velocity_y;
         end else begin
            req_valid <= 1'b0;
            if (pending_requests.size() == 0 && !hold_for_drain) stimulus_done = 1;
         end
      end
   end

   // Receiver stall pattern: free-running phases with ready windows.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_phase % 600 < 150)
            rsp_ready <= 1'b1;
         else if (stall_phase % 600 < 300)
            rsp_ready <= (stall_phase % 7) != 0;
         else
            rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Monitor: compare each result transfer with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_intervals.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected result low=%0d high=%0d", rsp_interval_low,
                        rsp_interval_high);
         end else begin
            interval_type want;
            want = expected_intervals.pop_front();
            if (rsp_interval_low !== want.low || rsp_interval_high !== want.high) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: interval exp [%0d, %0d] got [%0d, %0d]",
                           $signed(want.low), $signed(want.high), rsp_interval_low,
                           rsp_interval_high);
            end
         end
      end
   end

   // Reset, then wait for drain and a final settle.
   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && !req_valid && expected_intervals.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatch_count == 0 && expected_intervals.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- ellipse_axis_projection_interval.f -----
rtl/core/eapi_pkg.sv
rtl/core/eapi_cordic_cell.sv
rtl/core/eapi_sqrt_cell.sv
rtl/core/ellipse_axis_projection_interval.sv
tb/ellipse_axis_projection_interval_tb.sv
